/* hw/rtl/lsoq_pkg.sv */
package lsoq_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int ADDR_WIDTH_DEFAULT = 48;

   localparam int OP_W     = 2;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TOUCH  = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_WAS_EMPTY  = 3'd1,
      STATUS_NOW_EMPTY  = 3'd2,
      STATUS_TOO_FEW    = 3'd3,
      STATUS_MISSING    = 3'd4,
      STATUS_FULL       = 3'd5
   } status_type;

endpackage

/* hw/rtl/lsoq_ram.sv */
module lsoq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lru_slot_order_queue_core.sv */
// Ordered replacement list of up to DEPTH entries (address tag plus slot
// number), oldest first, held in one single-port-write / registered-read
// RAM and worked by a small sequencer that moves one entry at a time, a
// read then a write. start is taken when busy is low; busy stays high
// until the result beat, which appears on the rsp_ ports for exactly one
// cycle with rsp_valid high and cannot be stalled. Insert writes the new
// entry at the tail; remove pulls each later entry down one place; lookup
// scans every entry; touch searches for the slot, pulls the entries after
// it down and writes it last, or scans every entry when the slot is
// missing. Every result also carries the head entry, the count and an
// empty flag as they stand after the operation. There is no clearing pass
// after reset: only entries below the count are ever used.
module lru_slot_order_queue_core #(
   parameter int DEPTH      = lsoq_pkg::DEPTH_DEFAULT,
   parameter int ADDR_WIDTH = lsoq_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lsoq_pkg::OP_W-1:0]         req_op,
   input  logic [ADDR_WIDTH-1:0]             req_address,
   input  logic [lsoq_pkg::SLOT_W-1:0]       req_slot,
   output logic                              rsp_valid,
   output logic [lsoq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_found,
   output logic [lsoq_pkg::SLOT_W-1:0]       rsp_found_slot,
   output logic [ADDR_WIDTH-1:0]             rsp_oldest_address,
   output logic [lsoq_pkg::SLOT_W-1:0]       rsp_oldest_slot,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_entry_count,
   output logic                              rsp_is_empty
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SLOT_W  = lsoq_pkg::SLOT_W;
   localparam int ENTRY_W = ADDR_WIDTH + SLOT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INSERT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_TAIL_WR,
      S_HEAD_RD,
      S_HEAD_WAIT
   } state_type;

   state_type                    state_ff, state_in;
   lsoq_pkg::op_type             op_ff, op_in;
   logic [ADDR_WIDTH-1:0]        addr_ff, addr_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [ENTRY_W-1:0]           hold_ff, hold_in;
   lsoq_pkg::status_type         status_ff, status_in;
   logic                         found_ff, found_in;
   logic [SLOT_W-1:0]            fslot_ff, fslot_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lsoq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]            rsp_fslot_ff, rsp_fslot_in;
   logic [ADDR_WIDTH-1:0]        rsp_oaddr_ff, rsp_oaddr_in;
   logic [SLOT_W-1:0]            rsp_oslot_ff, rsp_oslot_in;
   logic [CNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   // RAM port
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [ENTRY_W-1:0]           wr_data;
   logic [IDX_W-1:0]             rd_addr;
   logic [ENTRY_W-1:0]           rd_data;
   logic [ADDR_WIDTH-1:0]        rd_address;
   logic [SLOT_W-1:0]            rd_slot;

   logic                         accept;
   logic [CNT_W-1:0]             idx_next;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign rd_address = rd_data[SLOT_W +: ADDR_WIDTH];
   assign rd_slot    = rd_data[SLOT_W-1:0];
   assign idx_next   = idx_ff + CNT_W'(1);

   lsoq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read address: scan reads the current index, the shift reads one ahead,
   // the closing read fetches the head.
   always_comb begin
      unique case (state_ff)
         S_SHIFT_RD: rd_addr = idx_next[IDX_W-1:0];
         S_HEAD_RD:  rd_addr = '0;
         default:    rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   // Write port: append, pull one entry down, or put the touched entry last.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_data;
      unique case (state_ff)
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = {addr_ff, slot_ff};
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         S_TAIL_WR: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(count_ff - CNT_W'(1));
            wr_data = hold_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hold_in       = hold_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      fslot_in      = fslot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fslot_in  = rsp_fslot_ff;
      rsp_oaddr_in  = rsp_oaddr_ff;
      rsp_oslot_in  = rsp_oslot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = lsoq_pkg::op_type'(req_op);
               addr_in   = req_address;
               slot_in   = req_slot;
               idx_in    = '0;
               status_in = lsoq_pkg::STATUS_OK;
               found_in  = 1'b0;
               fslot_in  = '0;
               unique case (lsoq_pkg::op_type'(req_op))
                  lsoq_pkg::OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = lsoq_pkg::STATUS_FULL;
                        state_in  = S_HEAD_RD;
                     end else begin
                        state_in = S_INSERT;
                     end
                  end
                  lsoq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = lsoq_pkg::STATUS_WAS_EMPTY;
                        state_in  = S_HEAD_RD;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end
                  lsoq_pkg::OP_TOUCH: begin
                     if (count_ff < CNT_W'(2)) begin
                        status_in = lsoq_pkg::STATUS_TOO_FEW;
                        state_in  = S_HEAD_RD;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = S_SCAN_RD;
                  end
               endcase
            end
         end

         S_INSERT: begin
            count_in = count_ff + CNT_W'(1);
            state_in = S_HEAD_RD;
         end

         S_SCAN_RD: begin
            if (idx_ff < count_ff) begin
               state_in = S_SCAN_CMP;
            end else begin
               // search ran off the end
               if (op_ff == lsoq_pkg::OP_TOUCH) begin
                  status_in = lsoq_pkg::STATUS_MISSING;
               end
               state_in = S_HEAD_RD;
            end
         end

         S_SCAN_CMP: begin
            if (op_ff == lsoq_pkg::OP_TOUCH) begin
               if (rd_slot == slot_ff) begin
                  // hold the oldest match, then close the gap at idx
                  hold_in  = rd_data;
                  state_in = S_SHIFT_RD;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SCAN_RD;
               end
            end else begin
               // lookup keeps the newest match
               if (rd_address == addr_ff) begin
                  found_in = 1'b1;
                  fslot_in = rd_slot;
               end
               idx_in   = idx_next;
               state_in = S_SCAN_RD;
            end
         end

         S_SHIFT_RD: begin
            if (idx_next < count_ff) begin
               state_in = S_SHIFT_WR;
            end else if (op_ff == lsoq_pkg::OP_TOUCH) begin
               state_in = S_TAIL_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  status_in = lsoq_pkg::STATUS_NOW_EMPTY;
               end
               state_in = S_HEAD_RD;
            end
         end

         S_SHIFT_WR: begin
            idx_in   = idx_next;
            state_in = S_SHIFT_RD;
         end

         S_TAIL_WR: begin
            state_in = S_HEAD_RD;
         end

         S_HEAD_RD: begin
            if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_fslot_in  = fslot_ff;
               rsp_oaddr_in  = '0;
               rsp_oslot_in  = '0;
               rsp_count_in  = count_ff;
               rsp_empty_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_HEAD_WAIT;
            end
         end

         S_HEAD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_found_in  = found_ff;
            rsp_fslot_in  = fslot_ff;
            rsp_oaddr_in  = rd_address;
            rsp_oslot_in  = rd_slot;
            rsp_count_in  = count_ff;
            rsp_empty_in  = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      hold_ff       <= hold_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      fslot_ff      <= fslot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fslot_ff  <= rsp_fslot_in;
      rsp_oaddr_ff  <= rsp_oaddr_in;
      rsp_oslot_ff  <= rsp_oslot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_slot     = rsp_fslot_ff;
   assign rsp_oldest_address = rsp_oaddr_ff;
   assign rsp_oldest_slot    = rsp_oslot_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

endmodule

/* hw/rtl/lsoq_checker.sv */
module lsoq_checker #(
   parameter int DEPTH      = lsoq_pkg::DEPTH_DEFAULT,
   parameter int ADDR_WIDTH = lsoq_pkg::ADDR_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [ADDR_WIDTH-1:0]         rsp_oldest_address,
   input logic [lsoq_pkg::SLOT_W-1:0]   rsp_oldest_slot,
   input logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count,
   input logic                          rsp_is_empty
);

   // one beat per operation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted beat did not start work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_oldest_address == '0) && (rsp_oldest_slot == '0))
      else $error("head entry not zero on empty list");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= ($clog2(DEPTH+1))'(DEPTH)))
      else $error("count above depth");

endmodule

bind lru_slot_order_queue_core lsoq_checker #(
   .DEPTH      (DEPTH),
   .ADDR_WIDTH (ADDR_WIDTH)
) u_lsoq_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_oldest_address (rsp_oldest_address),
   .rsp_oldest_slot    (rsp_oldest_slot),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_is_empty       (rsp_is_empty)
);
